[rtl/sha512_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-512 package
// Round constants, initial hash words and controller command/status types.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned Rounds   = 80;
  localparam int unsigned RndW     = 7;
  localparam int unsigned BufDepth = 16;
  localparam int unsigned PosW     = 4;
  localparam int unsigned VbW      = 4;
  localparam logic [7:0]  PadByte  = 8'h80;
  localparam logic [PosW-1:0] LenSlot = 4'd14;

  typedef logic [WordW-1:0] word_t;

  localparam word_t Iv [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t RoundK [Rounds] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  // word source selection for a push
  typedef enum logic [2:0] {
    SRC_MSG_E,
    SRC_PAD_E,
    SRC_ZERO_E,
    SRC_LEN_HI_E,
    SRC_LEN_LO_E
  } src_e;

  typedef struct packed {
    logic       load_in;    // capture input word and count
    logic       push;       // write one word into the block buffer
    src_e       src;
    logic       comp_start; // load working vars, clear round count
    logic       round;      // run one round
    logic       fold;       // add working vars into chain
    logic       emit;       // shift out one digest word
    logic       restart;    // back to initial state
  } dp_cmd_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            block_full;
    logic            rounds_done;
    logic            in_last;
    logic            in_full;
  } dp_stat_t;

endpackage

[rtl/sha512_ctrl.sv]
// ----------------------------------------------------------------------------
// SHA-512 controller
// Sequences word pushes, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha512_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sha512_pkg::dp_stat_t stat_i,
  output sha512_pkg::dp_cmd_t  cmd_o,
  output logic                 busy_o,
  output logic                 emit_o,
  output logic                 emit_last_o
);
  import sha512_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPush  = 4'd1;
  localparam logic [3:0] StPad   = 4'd2;
  localparam logic [3:0] StZero  = 4'd3;
  localparam logic [3:0] StLenHi = 4'd4;
  localparam logic [3:0] StLenLo = 4'd5;
  localparam logic [3:0] StInit  = 4'd6;
  localparam logic [3:0] StRound = 4'd7;
  localparam logic [3:0] StFold  = 4'd8;
  localparam logic [3:0] StEmit  = 4'd9;

  logic [3:0] state_q, state_d, ret_q, ret_d;
  logic [2:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
    end
  end

  // state to go to after a push, given the block state
  function automatic logic [3:0] after_push(input logic [3:0] nxt, input logic full);
    after_push = full ? StInit : nxt;
  endfunction

  logic [3:0] nxt_push;

  always_comb begin
    cmd_o       = '0;
    cmd_o.src   = SRC_MSG_E;
    state_d     = state_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    emit_o      = 1'b0;
    emit_last_o = 1'b0;
    nxt_push    = StIdle;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StPush;
        end
      end
      StPush: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = stat_i.in_last && !stat_i.in_full ? SRC_PAD_E : SRC_MSG_E;
        if (!stat_i.in_last) begin
          nxt_push = StIdle;
        end else if (stat_i.in_full) begin
          nxt_push = StPad;
        end else begin
          nxt_push = StZero;
        end
        ret_d   = nxt_push;
        state_d = after_push(nxt_push, stat_i.block_full);
      end
      StPad: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_PAD_E;
        ret_d      = StZero;
        state_d    = after_push(StZero, stat_i.block_full);
      end
      StZero: begin
        if (stat_i.pos == LenSlot) begin
          state_d = StLenHi;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.src  = SRC_ZERO_E;
          ret_d      = StZero;
          state_d    = after_push(StZero, stat_i.block_full);
        end
      end
      StLenHi: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_LEN_HI_E;
        state_d    = StLenLo;
      end
      StLenLo: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_LEN_LO_E;
        ret_d      = StEmit;
        cnt_d      = '0;
        state_d    = StInit;
      end
      StInit: begin
        cmd_o.comp_start = 1'b1;
        state_d          = StRound;
      end
      StRound: begin
        cmd_o.round = 1'b1;
        if (stat_i.rounds_done) state_d = StFold;
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        state_d    = ret_q;
      end
      StEmit: begin
        cmd_o.emit  = 1'b1;
        emit_o      = 1'b1;
        emit_last_o = &cnt_q;
        cnt_d       = cnt_q + 3'd1;
        if (&cnt_q) begin
          cmd_o.restart = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> busy_o) else $error("emit while idle");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_last_o |=> !busy_o) else $error("not idle after last digest word");
  a_start_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");

endmodule

[rtl/sha512_dp.sv]
// ----------------------------------------------------------------------------
// SHA-512 datapath
// Block buffer, message schedule, round logic, chain words and byte count.
// ----------------------------------------------------------------------------
module sha512_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sha512_pkg::WordW-1:0] word_i,
  input  logic [sha512_pkg::VbW-1:0] vb_i,
  input  logic                       last_i,
  input  sha512_pkg::dp_cmd_t        cmd_i,
  output sha512_pkg::dp_stat_t       stat_o,
  output logic [sha512_pkg::WordW-1:0] digest_o
);
  import sha512_pkg::*;

  word_t           in_word_q, pad_word;
  logic [3:0]      in_vb_q;
  logic            in_last_q;
  word_t           buf_q [BufDepth];
  word_t           w_q [BufDepth];
  word_t           h_q [8];
  word_t           v_q [8];
  word_t           byte_cnt_q;
  logic [PosW-1:0] pos_q;
  logic [RndW-1:0] rnd_q;
  word_t           push_word, keep, s0, s1, w_next;
  word_t           big0, big1, ch, maj, t1, t2;
  logic [3:0]      vb_sat;
  logic [6:0]      sh;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (WordW - n));
  endfunction

  assign vb_sat = (vb_i > 4'd8) ? 4'd8 : vb_i;
  assign sh     = 7'(64 - 8 * 32'(in_vb_q));
  assign keep   = (in_vb_q == 4'd0) ? '0 : ({WordW{1'b1}} << sh);
  assign pad_word = (in_word_q & keep) | (word_t'(PadByte) << (sh - 7'd8));

  always_comb begin
    unique case (cmd_i.src)
      SRC_MSG_E:    push_word = in_word_q;
      SRC_PAD_E:    push_word = in_last_q && in_vb_q != 4'd8 ? pad_word
                                                             : {PadByte, 56'd0};
      SRC_ZERO_E:   push_word = '0;
      SRC_LEN_HI_E: push_word = {61'd0, byte_cnt_q[63:61]};
      SRC_LEN_LO_E: push_word = {byte_cnt_q[60:0], 3'd0};
      default:      push_word = '0;
    endcase
  end

  assign s0     = ror(w_q[1], 1) ^ ror(w_q[1], 8) ^ (w_q[1] >> 7);
  assign s1     = ror(w_q[14], 19) ^ ror(w_q[14], 61) ^ (w_q[14] >> 6);
  assign w_next = w_q[0] + s0 + w_q[9] + s1;
  assign big1   = ror(v_q[4], 14) ^ ror(v_q[4], 18) ^ ror(v_q[4], 41);
  assign ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1     = v_q[7] + big1 + ch + RoundK[rnd_q] + w_q[0];
  assign big0   = ror(v_q[0], 28) ^ ror(v_q[0], 34) ^ ror(v_q[0], 39);
  assign maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2     = big0 + maj;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_word_q <= word_i;
      in_vb_q   <= last_i ? vb_sat : 4'd8;
      in_last_q <= last_i;
    end
    if (cmd_i.push) buf_q[pos_q] <= push_word;
    if (cmd_i.comp_start) begin
      w_q <= buf_q;
      v_q <= h_q;
    end else if (cmd_i.round) begin
      for (int i = 0; i < BufDepth - 1; i++) w_q[i] <= w_q[i+1];
      w_q[BufDepth-1] <= w_next;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q        <= Iv;
      byte_cnt_q <= '0;
      pos_q      <= '0;
      rnd_q      <= '0;
    end else begin
      if (cmd_i.load_in) begin
        byte_cnt_q <= byte_cnt_q + word_t'(last_i ? vb_sat : 4'd8);
      end
      if (cmd_i.push) pos_q <= pos_q + 1'b1;
      if (cmd_i.comp_start) begin
        rnd_q <= '0;
      end else if (cmd_i.round) begin
        rnd_q <= rnd_q + 1'b1;
      end
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end else if (cmd_i.restart) begin
        h_q        <= Iv;
        byte_cnt_q <= '0;
        pos_q      <= '0;
      end else if (cmd_i.emit) begin
        for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
        h_q[7] <= h_q[0];
      end
    end
  end

  assign digest_o           = h_q[0];
  assign stat_o.pos         = pos_q;
  assign stat_o.block_full  = (pos_q == 4'd15);
  assign stat_o.rounds_done = (rnd_q == RndW'(Rounds - 1));
  assign stat_o.in_last     = in_last_q;
  assign stat_o.in_full     = (in_vb_q == 4'd8);

  a_pos_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && cmd_i.src == SRC_LEN_LO_E) |-> pos_q == 4'd15)
    else $error("length word misplaced");
  a_round_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round |-> rnd_q < RndW'(Rounds))
    else $error("round count overrun");
  a_fold_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.comp_start |-> pos_q == '0)
    else $error("compression on partial block");

endmodule

[rtl/sha512_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-512 stream hasher
// Hashes a message of 64-bit words and emits the 512-bit digest as 8 words.
//
// Channel   Direction  Handshake             Payload
// input     in         start / busy          message_word_i, valid_bytes_i, is_last_i
// digest    out        digest_valid_o        digest_word_o, digest_last_o
//
// A non-last word is captured and pushed, and a block it completes is compressed.
// A last word pushes padding one word a cycle, pausing while a full block is compressed,
// compresses one or two blocks, then shows the eight digest words back to back.
// The 80-round loop of the single round unit sets the rate.
// Reset restores the initial hash words and clears the byte count.
// Digest words cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module sha512_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        is_last_i,
  output logic        digest_valid_o,
  output logic [63:0] digest_word_o,
  output logic        digest_last_o
);
  import sha512_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha512_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .emit_o      (digest_valid_o),
    .emit_last_o (digest_last_o)
  );

  sha512_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (message_word_i),
    .vb_i     (valid_bytes_i),
    .last_i   (is_last_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .digest_o (digest_word_o)
  );

endmodule

[dv/sha512_stream_hasher_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-512 stream hasher testbench
// Sends messages word by word through the start/busy command port. A
// reference hash in the bench queues the eight digest words of each message.
// The bench compares the words the block emits against that queue.
// A directed table comes first, then block-edge messages, then random messages of mixed length.
// ----------------------------------------------------------------------------
module sha512_stream_hasher_tb;
  import sha512_pkg::*;

  typedef struct {
    word_t      word;
    logic [3:0] vbytes;
    logic       last;
    bit         known;
    word_t      d0;
  } msg_row_t;

  typedef struct {
    word_t word;
    logic  last;
  } digest_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] message_word_i = '0;
  logic [3:0]  valid_bytes_i = '0;
  logic        is_last_i = 1'b0;
  logic        digest_valid_o;
  logic [63:0] digest_word_o;
  logic        digest_last_o;

  sha512_stream_hasher DUT (.*);

  always #2 clk_i = ~clk_i;

  word_t       hash_h [8];
  word_t       blk [16];
  logic [3:0]  blk_pos;
  word_t       msg_bytes;
  digest_exp_t digest_q [$];
  word_t       known_q [$];
  int unsigned mismatches = 0;
  int unsigned digests_seen = 0;
  int unsigned words_sent = 0;
  int unsigned messages = 0;
  int unsigned idle_cycles = 0;
  bit          timed_out = 0;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_blk();
    word_t w [80];
    word_t v [8];
    word_t t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 80; t++)
      w[t] = w[t-16] + (rotr(w[t-15], 1) ^ rotr(w[t-15], 8) ^ (w[t-15] >> 7))
             + w[t-7] + (rotr(w[t-2], 19) ^ rotr(w[t-2], 61) ^ (w[t-2] >> 6));
    for (int j = 0; j < 8; j++) v[j] = hash_h[j];
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_h[j] += v[j];
  endtask

  task automatic put_word(word_t w);
    blk[blk_pos] = w;
    blk_pos++;
    if (blk_pos == 0) compress_blk();
  endtask

  task automatic hash_restart();
    for (int j = 0; j < 8; j++) hash_h[j] = Iv[j];
    blk_pos = '0;
    msg_bytes = '0;
  endtask

  // advance the reference hash by one transferred word
  task automatic hash_word(word_t w, logic [3:0] vb, logic last);
    int   n;
    word_t keep;
    if (!last) begin
      msg_bytes += 8;
      put_word(w);
    end else begin
      n = (vb > 8) ? 8 : vb;
      msg_bytes += n;
      if (n == 8) begin
        put_word(w);
        put_word({PadByte, 56'd0});
      end else begin
        keep = (n == 0) ? '0 : ~64'd0 << (64 - 8 * n);
        put_word((w & keep) | (word_t'(PadByte) << (56 - 8 * n)));
      end
      while (blk_pos != LenSlot) put_word('0);
      put_word(msg_bytes >> 61);
      put_word(msg_bytes << 3);
      for (int k = 0; k < 8; k++) digest_q.push_back('{hash_h[k], k == 7});
      messages++;
      hash_restart();
    end
  endtask

  task automatic gap();
    int n;
    if ($urandom_range(0, 2) == 0) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // hold the word until the block takes it
  task automatic send(word_t w, logic [3:0] vb, logic last);
    start <= 1'b1;
    message_word_i <= w;
    valid_bytes_i <= vb;
    is_last_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    hash_word(w, vb, last);
    words_sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && !(start && !busy) && !digest_valid_o) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles > 5000) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    digest_exp_t e;
    word_t       k;
    if (rst_ni && digest_valid_o) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", digest_word_o);
      end else begin
        e = digest_q.pop_front();
        if (digest_word_o !== e.word || digest_last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%b got %h/%b",
                     e.word, e.last, digest_word_o, digest_last_o);
        end
        if (e.last == 1'b0 && known_q.size() > 0 && digests_seen % 8 == 1) begin
          k = known_q.pop_front();
          if (k !== 64'd0 && digest_word_o !== k) begin
            mismatches++;
            if (mismatches <= 10) $display("known digest: exp %h got %h", k, digest_word_o);
          end
        end
      end
    end
  end

  msg_row_t directed [] = '{
    '{64'h0, 4'd0, 1'b1, 1, 64'hcf83e1357eefb8bd},
    '{64'h6162630000000000, 4'd3, 1'b1, 1, 64'hddaf35a193617aba},
    '{64'hffffffffffffffff, 4'd8, 1'b1, 0, 64'h0},
    '{64'hffffffffffffffff, 4'd15, 1'b1, 0, 64'h0},
    '{64'h0123456789abcdef, 4'd9, 1'b1, 0, 64'h0},
    '{64'hffffffffffffffff, 4'd7, 1'b1, 0, 64'h0},
    '{64'hffffffffffffffff, 4'd1, 1'b1, 0, 64'h0},
    '{64'hffffffffffffffff, 4'd3, 1'b0, 0, 64'h0},
    '{64'h0, 4'd0, 1'b0, 0, 64'h0},
    '{64'ha5a5a5a5a5a5a5a5, 4'd4, 1'b1, 0, 64'h0}
  };

  initial begin
    int    len, tail;
    word_t w;
    hash_restart();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].last) known_q.push_back(directed[i].known ? directed[i].d0 : 64'd0);
      send(directed[i].word, directed[i].vbytes, directed[i].last);
      gap();
    end
    // padding near and across a block edge: 14, 15 and 16 words before the last one
    for (int m = 14; m <= 16; m++) begin
      for (int i = 0; i < m; i++) begin
        send({$urandom, $urandom}, 4'($urandom), 1'b0);
        if (i % 5 == 0) gap();
      end
      known_q.push_back(64'd0);
      send({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
    end

    while (words_sent < 320) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 17);
      for (int i = 0; i < len; i++) begin
        w = {$urandom, $urandom};
        send(w, 4'($urandom), 1'b0);
        gap();
      end
      tail = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      known_q.push_back(64'd0);
      send({$urandom, $urandom}, 4'(tail), 1'b1);
      gap();
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (digest_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d words in %0d messages, checked %0d digest words",
             words_sent, messages, digests_seen);
    if (mismatches == 0 && digest_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
